### src/descending_rank_of_values_macros.svh
`ifndef DESCENDING_RANK_OF_VALUES_MACROS_SVH
`define DESCENDING_RANK_OF_VALUES_MACROS_SVH

// same-cycle implication, held off during reset
`define DRV_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define DRV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/drv_pkg.sv
package drv_pkg;

  localparam int POS_W  = 6;
  localparam int RANK_W = 6;

  // a value travelling down the chain, with the count of stored values above it
  typedef struct packed {
    logic              vld;
    logic [RANK_W-1:0] cnt;
  } drv_tok_t;

  // what a cell holds: occupied flag and running rank
  typedef struct packed {
    logic              vld;
    logic [RANK_W-1:0] rank;
  } drv_slot_t;

  // control from the sequencer to every cell
  typedef struct packed {
    logic shift;
  } drv_ctl_t;

endpackage

### src/drv_cell.sv
module drv_cell
  import drv_pkg::*;
#(
  parameter int KEY_W = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  drv_ctl_t         ctl_i,
  input  drv_tok_t         tok_i,
  input  logic [KEY_W-1:0] tok_key_i,
  output drv_tok_t         tok_o,
  output logic [KEY_W-1:0] tok_key_o,
  input  drv_slot_t        slot_i,
  input  logic [KEY_W-1:0] slot_key_i,
  output drv_slot_t        slot_o,
  output logic [KEY_W-1:0] slot_key_o
);

  drv_tok_t         tok_r, tok_nxt;
  logic [KEY_W-1:0] tok_key_r;
  drv_slot_t        slot_r, slot_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic             greater;

  assign greater = $signed(key_r) > $signed(tok_key_i);

  always_comb begin
    slot_nxt = slot_r;
    key_nxt  = key_r;
    tok_nxt  = '0;
    if (ctl_i.shift) begin
      slot_nxt = slot_i;
      key_nxt  = slot_key_i;
    end else if (tok_i.vld) begin
      if (!slot_r.vld) begin
        // first empty cell takes the value
        slot_nxt.vld  = 1'b1;
        slot_nxt.rank = tok_i.cnt;
        key_nxt       = tok_key_i;
      end else begin
        // later arrival that is not smaller (ties included) pushes this one down
        if (!greater) slot_nxt.rank = slot_r.rank + RANK_W'(1);
        tok_nxt.vld = 1'b1;
        tok_nxt.cnt = tok_i.cnt + RANK_W'(greater);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r.vld <= 1'b0;
      tok_r.vld  <= 1'b0;
    end else begin
      slot_r.vld <= slot_nxt.vld;
      tok_r.vld  <= tok_nxt.vld;
    end
    slot_r.rank <= slot_nxt.rank;
    tok_r.cnt   <= tok_nxt.cnt;
    key_r       <= key_nxt;
    tok_key_r   <= tok_key_i;
  end

  assign tok_o      = tok_r;
  assign tok_key_o  = tok_key_r;
  assign slot_o     = slot_r;
  assign slot_key_o = key_r;

endmodule

### src/descending_rank_of_values.sv
// channel | direction | handshake       | payload
// in      | input     | in_valid/stall  | in_value, in_last
// out     | output    | out_valid/stall | out_position, out_rank, out_final_res, out_overflow
//
// loading takes one value per cycle: each value walks the cell chain one cell a cycle,
// bumping the ranks of values not greater than it, and settles in the first empty cell
// after the closing value the chain drains so the last value can reach its cell, then the
// results leave from cell 0 one per cycle while not stalled, as the chain shifts towards it
// in_stall is high from the closing value until the final result is taken
// reset is synchronous; all cells come out empty
module descending_rank_of_values
  import drv_pkg::*;
#(
  parameter int MAX_ITEMS   = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_value,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [POS_W-1:0]   out_position,
  output logic [RANK_W-1:0]  out_rank,
  output logic               out_final_res,
  output logic               out_overflow
);

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_DRAIN = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] drain_r, drain_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             ovf_r, ovf_nxt;

  logic             in_acc, out_acc, full;
  logic [VALUE_WIDTH-1:0] in_key;
  drv_ctl_t         ctl;

  drv_tok_t         tok_s      [0:MAX_ITEMS];
  logic [VALUE_WIDTH-1:0] tok_key_s  [0:MAX_ITEMS];
  drv_slot_t        slot_s     [0:MAX_ITEMS];
  logic [VALUE_WIDTH-1:0] slot_key_s [0:MAX_ITEMS];

  generate
    if (VALUE_WIDTH <= 32) begin : g_key_trunc
      assign in_key = in_value[VALUE_WIDTH-1:0];
    end else begin : g_key_ext
      assign in_key = {{(VALUE_WIDTH-32){in_value[31]}}, in_value};
    end
  endgenerate

  assign full     = cnt_r == CNT_W'(MAX_ITEMS);
  assign in_stall = state_r != ST_LOAD;
  assign in_acc   = in_valid && !in_stall;
  assign out_valid = state_r == ST_EMIT;
  assign out_acc  = out_valid && !out_stall;
  assign ctl.shift = out_acc;

  assign tok_s[0].vld   = in_acc && !full;
  assign tok_s[0].cnt   = '0;
  assign tok_key_s[0]   = in_key;
  assign slot_s[MAX_ITEMS]     = '0;
  assign slot_key_s[MAX_ITEMS] = '0;

  generate
    for (genvar gi = 0; gi < MAX_ITEMS; gi++) begin : g_cell
      drv_cell #(
        .KEY_W(VALUE_WIDTH)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl_i     (ctl),
        .tok_i     (tok_s[gi]),
        .tok_key_i (tok_key_s[gi]),
        .tok_o     (tok_s[gi+1]),
        .tok_key_o (tok_key_s[gi+1]),
        .slot_i    (slot_s[gi+1]),
        .slot_key_i(slot_key_s[gi+1]),
        .slot_o    (slot_s[gi]),
        .slot_key_o(slot_key_s[gi])
      );
    end
  endgenerate

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    drain_nxt = drain_r;
    idx_nxt   = idx_r;
    ovf_nxt   = ovf_r;
    case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (full) ovf_nxt = 1'b1;
          else      cnt_nxt = cnt_r + CNT_W'(1);
          if (in_last) begin
            state_nxt = ST_DRAIN;
            drain_nxt = CNT_W'(MAX_ITEMS - 1);
          end
        end
      end
      ST_DRAIN: begin
        // let the last transaction's value reach its cell
        if (drain_r == '0) state_nxt = ST_EMIT;
        else               drain_nxt = drain_r - CNT_W'(1);
      end
      ST_EMIT: begin
        if (out_acc) begin
          if (out_final_res) begin
            state_nxt = ST_LOAD;
            cnt_nxt   = '0;
            idx_nxt   = '0;
            ovf_nxt   = 1'b0;
          end else begin
            idx_nxt = idx_r + CNT_W'(1);
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      drain_r <= '0;
      idx_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      drain_r <= drain_nxt;
      idx_r   <= idx_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  assign out_position  = POS_W'(idx_r);
  assign out_rank      = slot_s[0].rank;
  assign out_final_res = (idx_r + CNT_W'(1)) == cnt_r;
  assign out_overflow  = ovf_r;

endmodule

### src/drv_checker.sv
`include "descending_rank_of_values_macros.svh"

module drv_checker
  import drv_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [POS_W-1:0]  out_position,
  input logic [RANK_W-1:0] out_rank,
  input logic              out_final_res
);

  `DRV_ASSERT_SAME(a_no_load_in_emit, out_valid, in_stall, "input open during emission")
  `DRV_ASSERT_SAME(a_first_pos_zero, $rose(out_valid), out_position == '0,
    "run does not start at position zero")
  `DRV_ASSERT_NEXT(a_pos_step, out_valid && !out_stall && !out_final_res,
    out_valid && out_position == POS_W'($past(out_position) + POS_W'(1)),
    "positions not consecutive")
  `DRV_ASSERT_NEXT(a_run_ends, out_valid && !out_stall && out_final_res, !out_valid,
    "results continue after the final transaction")
  `DRV_ASSERT_NEXT(a_stall_hold, out_valid && out_stall,
    out_valid && $stable(out_rank) && $stable(out_position), "stalled result changed")

endmodule

bind descending_rank_of_values drv_checker u_drv_checker (.*);
